### src/assert_macros.svh
// Assertion macros used by the RTL of the neuron update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/izh_pkg.sv
// Package with payload types, register codes, constants and fixed-point helpers.
package izh_pkg;

    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 4;

    localparam int NEURONS_DEF = 256;
    localparam logic signed [31:0] RESET_POTENTIAL_DEF = -32'sd4259840;

    localparam logic signed [31:0] MEMBRANE_RESET = 32'sd0;
    // Recovery starts at the reset value of the peak potential.
    localparam logic signed [31:0] RECOVERY_RESET = 32'sd1966080;

    localparam logic [30:0]        DTC_RESET   = 31'd262;
    localparam logic [30:0]        GAIN_RESET  = 31'd163840;
    localparam logic [30:0]        RATE_RESET  = 31'd655;
    localparam logic signed [31:0] B_RESET     = -32'sd131072;
    localparam logic signed [31:0] D_RESET     = 32'sd13107200;
    localparam logic signed [31:0] VR_RESET    = -32'sd3932160;
    localparam logic signed [31:0] VT_RESET    = -32'sd1258291;
    localparam logic signed [31:0] VPEAK_RESET = 32'sd1966080;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_OVER_CAP  = 4'd0,
        REG_GAIN_K         = 4'd1,
        REG_RECOVERY_RATE  = 4'd2,
        REG_RECOVERY_SENS  = 4'd3,
        REG_SPIKE_JUMP     = 4'd4,
        REG_REST_POTENTIAL = 4'd5,
        REG_THRESHOLD      = 4'd6,
        REG_PEAK_POTENTIAL = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]         neuron_index;
        logic signed [DATA_W-1:0] input_current;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] spike_neuron;
        logic             spike;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) return Q_MAX;
        if (x < 64'shFFFF_FFFF_8000_0000) return Q_MIN;
        return $signed(x[31:0]);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] t;
        t = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
        return sat32(t);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] t;
        t = $signed({{32{a[31]}}, a}) - $signed({{32{b[31]}}, b});
        return sat32(t);
    endfunction

    // Q16.16 product: exact 64-bit product, floor shift by 16, saturate.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [63:0] p;
        p = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
        return sat32(p >>> 16);
    endfunction

endpackage

### src/izhikevich_neuron_update.sv
// Top level of the pipelined Izhikevich neuron update with its state memories.
//
// Each input item on the s_ channel names a neuron and carries its input current.
// The block reads that neuron's membrane potential and recovery variable from
// on-chip memory, takes one Euler step in saturating Q16.16 arithmetic, writes
// both back and returns one item on the m_ channel: the neuron index and a
// spike flag. Indexes at or above NEURONS change nothing and never spike.
// From input acceptance to m_valid an item passes through seven compute
// stages and the output register. One item is accepted per cycle; an item that
// names a neuron still inside the pipeline waits until that earlier update has
// been written back, which happens as it leaves stage 7 for the output register
// at the end of the read-compute-write loop through the state memories.
// Stages advance independently, so bubbles close up and items keep entering
// while a result waits in the output register; when m_ready stays low the
// pipeline fills and then s_ready drops, and nothing is lost or repeated.
// The configuration channel is always ready and should be written only while
// the block is idle. Reset restores the register defaults and clears one valid
// bit per neuron at once, so all potentials read as zero and all recovery
// variables as the default peak potential; no clearing pass is needed.
module izhikevich_neuron_update #(
    parameter int                 NEURONS             = izh_pkg::NEURONS_DEF,
    parameter logic signed [31:0] RESET_POTENTIAL_Q16 = izh_pkg::RESET_POTENTIAL_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  izh_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output izh_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [izh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [izh_pkg::DATA_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    // Only the first 256 neurons are reachable through the 8-bit index.
    localparam int DEPTH = (NEURONS < 256) ? NEURONS : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] NEURONS_L = 17'(NEURONS);

    // Configuration registers.
    logic [30:0]        dtc_reg, gain_reg, rate_reg;
    logic signed [31:0] b_reg, d_reg, vr_reg, vt_reg, vpeak_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dtc_reg   <= izh_pkg::DTC_RESET;
            gain_reg  <= izh_pkg::GAIN_RESET;
            rate_reg  <= izh_pkg::RATE_RESET;
            b_reg     <= izh_pkg::B_RESET;
            d_reg     <= izh_pkg::D_RESET;
            vr_reg    <= izh_pkg::VR_RESET;
            vt_reg    <= izh_pkg::VT_RESET;
            vpeak_reg <= izh_pkg::VPEAK_RESET;
        end else if (cfg_valid) begin
            case (izh_pkg::cfg_reg_t'(cfg_index))
                izh_pkg::REG_STEP_OVER_CAP:  dtc_reg   <= cfg_data[30:0];
                izh_pkg::REG_GAIN_K:         gain_reg  <= cfg_data[30:0];
                izh_pkg::REG_RECOVERY_RATE:  rate_reg  <= cfg_data[30:0];
                izh_pkg::REG_RECOVERY_SENS:  b_reg     <= $signed(cfg_data);
                izh_pkg::REG_SPIKE_JUMP:     d_reg     <= $signed(cfg_data);
                izh_pkg::REG_REST_POTENTIAL: vr_reg    <= $signed(cfg_data);
                izh_pkg::REG_THRESHOLD:      vt_reg    <= $signed(cfg_data);
                izh_pkg::REG_PEAK_POTENTIAL: vpeak_reg <= $signed(cfg_data);
                default: ; // Indexes beyond the register list are ignored.
            endcase
        end
    end

    // Pipeline control. Stage k moves forward when it is empty or the next
    // stage moves; stage 8 is the output register.
    localparam int IDX_W_C = izh_pkg::IDX_W;

    logic [7:1]          vld_reg;
    logic [7:1]          inr_reg;
    logic [IDX_W_C-1:0]  idx_reg [1:7];
    logic [8:1]          adv;
    logic                out_valid_reg, out_spike_reg, out_inr_reg;
    logic [izh_pkg::IDX_W-1:0] out_idx_reg;

    always_comb begin
        adv[8] = !out_valid_reg || m_ready;
        for (int k = 7; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // An item may not enter while an earlier update of the same neuron is in
    // flight, since its state has not been written back yet.
    logic hazard;
    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= 7; k++) begin
            if (vld_reg[k] && inr_reg[k] && idx_reg[k] == s_data.neuron_index) begin
                hazard = 1'b1;
            end
        end
    end

    logic in_accept, s_inr;
    assign s_ready   = adv[1] && !hazard;
    assign in_accept = s_valid && s_ready;
    assign s_inr     = {9'd0, s_data.neuron_index} < NEURONS_L;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv[8]) out_valid_reg <= vld_reg[7];
            for (int k = 7; k >= 2; k--) begin
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
            end
            if (adv[1]) vld_reg[1] <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 7; k >= 2; k--) begin
            if (adv[k]) begin
                idx_reg[k] <= idx_reg[k-1];
                inr_reg[k] <= inr_reg[k-1];
            end
        end
        if (adv[1]) begin
            idx_reg[1] <= s_data.neuron_index;
            inr_reg[1] <= s_inr;
        end
    end

    // State memories with one valid bit per neuron. An entry never written
    // reads as the reset value.
    logic [31:0]     mem_v [DEPTH];
    logic [31:0]     mem_u [DEPTH];
    logic [DEPTH-1:0] ent_vld_reg;
    logic [31:0]     rd_v_reg, rd_u_reg;
    logic            rd_vld_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic signed [31:0] vn, un;

    assign rd_addr = s_data.neuron_index[AW-1:0];
    assign wr_addr = idx_reg[7][AW-1:0];
    assign wr_en   = adv[8] && vld_reg[7] && inr_reg[7];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_v[wr_addr] <= vn;
            mem_u[wr_addr] <= un;
        end
        if (adv[1]) begin
            rd_v_reg <= mem_v[rd_addr];
            rd_u_reg <= mem_u[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) ent_vld_reg[wr_addr] <= 1'b1;
            if (adv[1]) rd_vld_reg <= ent_vld_reg[rd_addr];
        end
    end

    // Datapath. Stage 1 holds the memory read data and the current.
    logic signed [31:0] cur1_reg;
    always_ff @(posedge aclk) begin
        if (adv[1]) cur1_reg <= s_data.input_current;
    end

    // Stage 2: choose reset values for unwritten entries, form v-vr and v-vt.
    logic signed [31:0] v1, u1;
    logic signed [31:0] v2_reg, u2_reg, dvr2_reg, dvt2_reg, cur2_reg;
    assign v1 = rd_vld_reg ? $signed(rd_v_reg) : izh_pkg::MEMBRANE_RESET;
    assign u1 = rd_vld_reg ? $signed(rd_u_reg) : izh_pkg::RECOVERY_RESET;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            v2_reg   <= v1;
            u2_reg   <= u1;
            dvr2_reg <= izh_pkg::sat_sub(v1, vr_reg);
            dvt2_reg <= izh_pkg::sat_sub(v1, vt_reg);
            cur2_reg <= cur1_reg;
        end
    end

    // Stage 3: k*(v-vr) and b*(v-vr).
    logic signed [31:0] v3_reg, u3_reg, dvt3_reg, cur3_reg, m13_reg, mb3_reg;
    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            v3_reg   <= v2_reg;
            u3_reg   <= u2_reg;
            dvt3_reg <= dvt2_reg;
            cur3_reg <= cur2_reg;
            m13_reg  <= izh_pkg::mulq($signed({1'b0, gain_reg}), dvr2_reg);
            mb3_reg  <= izh_pkg::mulq(b_reg, dvr2_reg);
        end
    end

    // Stage 4: quadratic term and recovery drive.
    logic signed [31:0] v4_reg, u4_reg, cur4_reg, p4_reg, e4_reg;
    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            v4_reg   <= v3_reg;
            u4_reg   <= u3_reg;
            cur4_reg <= cur3_reg;
            p4_reg   <= izh_pkg::mulq(m13_reg, dvt3_reg);
            e4_reg   <= izh_pkg::sat_sub(mb3_reg, u3_reg);
        end
    end

    // Stage 5: p-u and (dt*a)*e.
    logic signed [31:0] v5_reg, u5_reg, cur5_reg, s15_reg, me5_reg;
    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            v5_reg   <= v4_reg;
            u5_reg   <= u4_reg;
            cur5_reg <= cur4_reg;
            s15_reg  <= izh_pkg::sat_sub(p4_reg, u4_reg);
            me5_reg  <= izh_pkg::mulq($signed({1'b0, rate_reg}), e4_reg);
        end
    end

    // Stage 6: add the current, form the new recovery value.
    logic signed [31:0] v6_reg, s6_reg, un6_reg;
    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            v6_reg  <= v5_reg;
            s6_reg  <= izh_pkg::sat_add(s15_reg, cur5_reg);
            un6_reg <= izh_pkg::sat_add(u5_reg, me5_reg);
        end
    end

    // Stage 7: (dt/C)*s, and the recovery value with the spike jump ready.
    logic signed [31:0] v7_reg, ms7_reg, un7_reg, unj7_reg;
    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            v7_reg   <= v6_reg;
            ms7_reg  <= izh_pkg::mulq($signed({1'b0, dtc_reg}), s6_reg);
            un7_reg  <= un6_reg;
            unj7_reg <= izh_pkg::sat_add(un6_reg, d_reg);
        end
    end

    // Last step: new potential, peak test and write-back values.
    logic signed [31:0] vn_raw;
    logic               fire;
    assign vn_raw = izh_pkg::sat_add(v7_reg, ms7_reg);
    assign fire   = inr_reg[7] && (vn_raw >= vpeak_reg);
    assign vn     = fire ? RESET_POTENTIAL_Q16 : vn_raw;
    assign un     = fire ? unj7_reg : un7_reg;

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            out_idx_reg   <= idx_reg[7];
            out_spike_reg <= fire;
            out_inr_reg   <= inr_reg[7];
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_data.spike_neuron = out_idx_reg;
    assign m_data.spike        = out_spike_reg;

    `ASSERT_SAME(a_no_rw_collision, aclk, aresetn, wr_en && in_accept && s_inr, wr_addr != rd_addr)
    `ASSERT_SAME(a_spike_in_range, aclk, aresetn, m_valid && m_data.spike, out_inr_reg)
    `ASSERT_NEXT(a_written_is_valid, aclk, aresetn, wr_en, ent_vld_reg[$past(wr_addr)])

endmodule
